FILE: rtl/core/itfr_pkg.sv
// Package for the idle-timeout frame receiver: ring sizing, frame layout,
// request codes and port widths.
// Depends on nothing; imported by the receiver core and referenced by its checker.
`default_nettype none

package itfr_pkg;

    // Receive ring; the depth must stay a power of two so the pointers wrap
    // by truncation.
    localparam int RING_DEPTH = 256;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = PTR_W + 1;

    // Frame layout
    localparam int FRAME_BYTES = 14;
    localparam int FIDX_W      = $clog2(FRAME_BYTES + 1);
    localparam int SUM_SPAN    = 13;
    localparam int FLD_FIRST   = 3;
    localparam int FLD_LAST    = 12;

    localparam logic [7:0] HDR_ADDR = 8'h02;
    localparam logic [7:0] HDR_LEN  = 8'(FRAME_BYTES);
    localparam logic [7:0] HDR_CMD  = 8'h01;

    // Current word: low bits are the magnitude, one bit selects tenth-amp units
    localparam int MAG_W     = 14;
    localparam int TENTH_BIT = 14;
    localparam int TENTHS_W  = 18;

    localparam logic [7:0] MISS_MAX      = 8'hFF;
    localparam logic [7:0] IDLE_MAX      = 8'hFF;
    localparam logic [7:0] TIMEOUT_RESET = 8'd5;

    // Request kinds on the input stream
    typedef enum logic {
        REQ_BYTE = 1'b0,
        REQ_TICK = 1'b1
    } req_type_t;

    // Register map
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam logic REG_IDLE_TIMEOUT = 1'b0;

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 112;
    localparam int M_TUSER_W = 2;

endpackage

`default_nettype wire

FILE: rtl/core/idle_timeout_frame_receiver.sv
// Idle-timeout frame receiver core: byte ring, frame sequencer, status store.
// Depends on itfr_pkg.
//
// Usage: the input stream carries one request per transfer. s_tuser selects
// the kind: 0 pushes the byte in s_tdata into a 256-byte receive ring (the
// oldest byte is dropped when the ring is full), 1 is a millisecond tick.
// Ticks after the last byte count idle time; when the count reaches the
// rx_idle_timeout_ms register (APB address 0) the frame closes and exactly
// one result leaves on the output stream. Bytes and ticks that do not close a
// frame produce nothing.
// Flow: a byte or non-closing tick is taken in the idle state. A close with at least 14
// bytes held reads the 14 oldest ring entries through the single memory read
// port, one per cycle, checking header and XOR checksum with one shared
// compare/XOR unit; the result is then registered in the output register, and
// s_tready stays low meanwhile. A short close goes straight to the emit state
// and empties the ring.
// Results sit in an output register; new bytes and ticks are accepted while it
// waits, but a further close holds s_tready low until the result is taken.
// Reset empties the ring, clears all counters and status and loads a timeout
// of 5 ms; the ring memory itself is not cleared.
`default_nettype none

module idle_timeout_frame_receiver (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [itfr_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] rx_byte
    input  wire logic                          s_tuser,   // [0] req_type
    // Output stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [7:0] miss_count, [15:8] status_flags_one, [23:16] status_flags_two,
    // [39:24] current_word, [57:40] current_tenths, [65:58] amp_ratio,
    // [81:66] speed_period_ms, [89:82] battery_level, [105:90] range_left,
    // [111:106] zero
    output logic [itfr_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [itfr_pkg::M_TUSER_W-1:0]     m_tuser,   // [0] link_ok, [1] frame_valid
    // Configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [itfr_pkg::APB_AW-1:0]   paddr,
    input  wire logic [itfr_pkg::APB_DW-1:0]   pwdata,
    output logic [itfr_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);
    import itfr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [PTR_W-1:0]     wptr_reg, wptr_next;
    logic [PTR_W-1:0]     rptr_reg, rptr_next;
    logic [CNT_W-1:0]     held_reg, held_next;
    logic [7:0]           idle_reg, idle_next;
    logic                 pending_reg, pending_next;
    logic [7:0]           miss_reg, miss_next;
    logic                 link_reg, link_next;
    logic                 valid_reg, valid_next;
    logic [7:0]           timeout_reg, timeout_next;
    logic [FIDX_W-1:0]    cnt_reg, cnt_next;
    logic [7:0]           xor_reg, xor_next;
    logic                 chk_reg, chk_next;
    logic [7:0]           frm_reg [FLD_FIRST:FLD_LAST];
    logic [7:0]           frm_next [FLD_FIRST:FLD_LAST];

    logic [7:0]           flags1_reg, flags1_next;
    logic [7:0]           flags2_reg, flags2_next;
    logic [15:0]          cur_reg, cur_next;
    logic [7:0]           ratio_reg, ratio_next;
    logic [15:0]          speed_reg, speed_next;
    logic [7:0]           batt_reg, batt_next;
    logic [15:0]          range_reg, range_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    // Ring memory
    logic [7:0]           ring_mem [RING_DEPTH];
    logic [7:0]           mem_q_reg;
    logic                 ring_wr;
    logic [PTR_W-1:0]     rd_addr;

    logic                 cfg_wr;
    logic [7:0]           limit;
    logic [7:0]           idle_inc;
    logic [FIDX_W-1:0]    bidx;
    logic                 chk_byte;
    logic [MAG_W-1:0]     cur_mag;
    logic [TENTHS_W-1:0]  tenths;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_IDLE_TIMEOUT) ? {24'd0, timeout_reg} : '0;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign limit    = (timeout_reg == 8'd0) ? 8'd1 : timeout_reg;
    assign idle_inc = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 8'd1;
    assign rd_addr  = rptr_reg + PTR_W'(cnt_reg);
    assign bidx     = cnt_reg - FIDX_W'(1);

    // Tenths of an ampere: magnitude as is, or times ten as 8m + 2m.
    assign cur_mag  = cur_reg[MAG_W-1:0];
    assign tenths   = cur_reg[TENTH_BIT] ? TENTHS_W'(cur_mag)
                    : (TENTHS_W'(cur_mag) << 3) + (TENTHS_W'(cur_mag) << 1);

    always_ff @(posedge clk)
    begin
        if (ring_wr)
        begin
            ring_mem[wptr_reg] <= s_tdata;
        end
        mem_q_reg <= ring_mem[rd_addr];
    end

    // Shared check unit: one byte per cycle against the header and checksum.
    always_comb
    begin
        chk_byte = 1'b1;
        case (bidx)
            FIDX_W'(0):        chk_byte = (mem_q_reg == HDR_ADDR);
            FIDX_W'(1):        chk_byte = (mem_q_reg == HDR_LEN);
            FIDX_W'(2):        chk_byte = (mem_q_reg == HDR_CMD);
            FIDX_W'(SUM_SPAN): chk_byte = (mem_q_reg == xor_reg);
            default:           chk_byte = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        wptr_next     = wptr_reg;
        rptr_next     = rptr_reg;
        held_next     = held_reg;
        idle_next     = idle_reg;
        pending_next  = pending_reg;
        miss_next     = miss_reg;
        link_next     = link_reg;
        valid_next    = valid_reg;
        timeout_next  = timeout_reg;
        cnt_next      = cnt_reg;
        xor_next      = xor_reg;
        chk_next      = chk_reg;
        frm_next      = frm_reg;
        flags1_next   = flags1_reg;
        flags2_next   = flags2_reg;
        cur_next      = cur_reg;
        ratio_next    = ratio_reg;
        speed_next    = speed_reg;
        batt_next     = batt_reg;
        range_next    = range_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        ring_wr       = 1'b0;

        if (cfg_wr && (paddr[2] == REG_IDLE_TIMEOUT))
        begin
            timeout_next = pwdata[7:0];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == REQ_BYTE)
                    begin
                        ring_wr      = 1'b1;
                        wptr_next    = wptr_reg + PTR_W'(1);
                        if (held_reg == CNT_W'(RING_DEPTH))
                        begin
                            rptr_next = rptr_reg + PTR_W'(1);
                        end
                        else
                        begin
                            held_next = held_reg + CNT_W'(1);
                        end
                        idle_next    = 8'd0;
                        pending_next = 1'b1;
                    end
                    else if (pending_reg)
                    begin
                        idle_next = idle_inc;
                        if (idle_inc >= limit)
                        begin
                            pending_next = 1'b0;
                            if (held_reg >= CNT_W'(FRAME_BYTES))
                            begin
                                link_next  = 1'b1;
                                miss_next  = 8'd0;
                                cnt_next   = '0;
                                xor_next   = 8'd0;
                                chk_next   = 1'b1;
                                state_next = ST_FETCH;
                            end
                            else
                            begin
                                wptr_next  = '0;
                                rptr_next  = '0;
                                held_next  = '0;
                                link_next  = 1'b0;
                                valid_next = 1'b0;
                                if (miss_reg != MISS_MAX)
                                begin
                                    miss_next = miss_reg + 8'd1;
                                end
                                state_next = ST_EMIT;
                            end
                        end
                    end
                end
            end

            ST_FETCH:
            begin
                // Read for byte cnt is issued now; the byte before it is in mem_q_reg.
                cnt_next = cnt_reg + FIDX_W'(1);
                if (cnt_reg != '0)
                begin
                    chk_next = chk_reg && chk_byte;
                    if (bidx < FIDX_W'(SUM_SPAN))
                    begin
                        xor_next = xor_reg ^ mem_q_reg;
                    end
                    if ((bidx >= FIDX_W'(FLD_FIRST)) && (bidx <= FIDX_W'(FLD_LAST)))
                    begin
                        frm_next[bidx] = mem_q_reg;
                    end
                end
                if (cnt_reg == FIDX_W'(FRAME_BYTES))
                begin
                    rptr_next  = rptr_reg + PTR_W'(FRAME_BYTES);
                    held_next  = held_reg - CNT_W'(FRAME_BYTES);
                    valid_next = chk_reg && chk_byte;
                    if (chk_reg && chk_byte)
                    begin
                        flags1_next = frm_reg[3];
                        flags2_next = frm_reg[4];
                        cur_next    = {frm_reg[5], frm_reg[6]};
                        ratio_next  = frm_reg[7];
                        speed_next  = {frm_reg[8], frm_reg[9]};
                        batt_next   = frm_reg[10];
                        range_next  = {frm_reg[11], frm_reg[12]};
                    end
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0, range_reg, batt_reg, speed_reg, ratio_reg,
                                     tenths, cur_reg, flags2_reg, flags1_reg, miss_reg};
                    m_tuser_next  = {valid_reg, link_reg};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            wptr_reg     <= '0;
            rptr_reg     <= '0;
            held_reg     <= '0;
            idle_reg     <= 8'd0;
            pending_reg  <= 1'b0;
            miss_reg     <= 8'd0;
            link_reg     <= 1'b0;
            valid_reg    <= 1'b0;
            timeout_reg  <= TIMEOUT_RESET;
            cnt_reg      <= '0;
            chk_reg      <= 1'b0;
            flags1_reg   <= 8'd0;
            flags2_reg   <= 8'd0;
            cur_reg      <= 16'd0;
            ratio_reg    <= 8'd0;
            speed_reg    <= 16'd0;
            batt_reg     <= 8'd0;
            range_reg    <= 16'd0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wptr_reg     <= wptr_next;
            rptr_reg     <= rptr_next;
            held_reg     <= held_next;
            idle_reg     <= idle_next;
            pending_reg  <= pending_next;
            miss_reg     <= miss_next;
            link_reg     <= link_next;
            valid_reg    <= valid_next;
            timeout_reg  <= timeout_next;
            cnt_reg      <= cnt_next;
            chk_reg      <= chk_next;
            flags1_reg   <= flags1_next;
            flags2_reg   <= flags2_next;
            cur_reg      <= cur_next;
            ratio_reg    <= ratio_next;
            speed_reg    <= speed_next;
            batt_reg     <= batt_next;
            range_reg    <= range_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        xor_reg     <= xor_next;
        frm_reg     <= frm_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/itfr_checker.sv
// Port-level checker for the idle-timeout frame receiver, bound to the receiver core.
// Depends on itfr_pkg for port widths.
`default_nettype none

module itfr_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [itfr_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [itfr_pkg::M_TUSER_W-1:0] m_tuser
);
    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output request dropped while stalled");

    // A frame can only be valid if it was full length.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("frame_valid without link_ok");

    // The miss count is zero exactly when the link is good.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[0] == (m_tdata[7:0] == 8'd0)))
        else $error("miss_count disagrees with link_ok");

    // Current in tenths follows from the current word.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[38] ? (m_tdata[57:40] == {4'd0, m_tdata[37:24]})
                                  : (m_tdata[57:40] == ({4'd0, m_tdata[37:24]} * 18'd10))))
        else $error("current_tenths inconsistent with current_word");

endmodule

bind idle_timeout_frame_receiver itfr_checker u_itfr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
